// ===== rtl/core/qat_pkg.sv =====
// ----------------------------------------------------------------------------
// qat_pkg: shared types and constants of the quoted argument tokenizer
// Result kinds, status codes, character codes and the bundle that carries
// all results of one input beat from the front end to the back end.
// ----------------------------------------------------------------------------
package qat_pkg;

    localparam int POS_W   = 10;
    localparam int SLOTS   = 4;
    localparam int CNT_W   = 3;

    // Result kinds.
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_WEND = 2'd1;
    localparam logic [1:0] KIND_STAT = 2'd2;

    // Line status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_NONISO   = 3'd2;
    localparam logic [2:0] ST_EMPTYQ   = 3'd3;
    localparam logic [2:0] ST_UNPAIRED = 3'd4;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    localparam logic [POS_W-1:0] WORDS_CAP = 10'd1023;

    // Bundle queue between front and back end.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } qat_slot_t;

    typedef struct packed {
        logic [CNT_W-1:0]         count;
        qat_slot_t [SLOTS-1:0]    slot;
        logic [2:0]               status;
        logic [POS_W-1:0]         error_pos;
        logic [POS_W-1:0]         quote_pos;
        logic [POS_W-1:0]         word_total;
    } qat_bundle_t;

    // Queue status seen by its two users.
    typedef struct packed {
        logic full;
        logic empty;
    } qat_qstat_t;

endpackage

// ===== rtl/core/qat_front.sv =====
// ----------------------------------------------------------------------------
// qat_front: character classifier and line state of the tokenizer
// Accepts one character beat per cycle while the queue has room, updates the quote
// and word state and builds a bundle of up to four results for the queue.
// ----------------------------------------------------------------------------
module qat_front #(
    parameter int MAX_LINE = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_char_in,
    input  logic                       s_no_char,
    input  logic                       s_line_end,
    input  qat_pkg::qat_qstat_t        qstat,
    output logic                       push,
    output qat_pkg::qat_bundle_t       push_data
);

    localparam logic [qat_pkg::POS_W-1:0] POS_CAP =
        (MAX_LINE - 1 < 1023) ? qat_pkg::POS_W'(MAX_LINE - 1) : qat_pkg::POS_W'(1023);

    logic                        accept;
    logic                        in_quotes_reg, in_quotes_next;
    logic                        prev_space_reg, prev_space_next;
    logic                        close_pending_reg, close_pending_next;
    logic                        close_empty_reg, close_empty_next;
    logic                        word_open_reg, word_open_next;
    logic                        ws_pending_reg, ws_pending_next;
    logic [7:0]                  ws_char_reg, ws_char_next;
    logic [qat_pkg::POS_W-1:0]   char_pos_reg, char_pos_next;
    logic [qat_pkg::POS_W-1:0]   oq_pos_reg, oq_pos_next;
    logic [qat_pkg::POS_W-1:0]   words_reg, words_next;
    logic [2:0]                  err_code_reg, err_code_next;
    logic [qat_pkg::POS_W-1:0]   err_at_reg, err_at_next;
    logic [qat_pkg::CNT_W-1:0]   n;
    logic                        take_ok;
    logic                        upd_ps;
    qat_pkg::qat_bundle_t        bundle;

    // No beat is taken while reset is held.
    assign s_ready   = aresetn && !qstat.full;
    assign accept    = s_valid && s_ready;
    assign push      = accept && (bundle.count != '0);
    assign push_data = bundle;

    always_comb begin
        in_quotes_next     = in_quotes_reg;
        prev_space_next    = prev_space_reg;
        close_pending_next = close_pending_reg;
        close_empty_next   = close_empty_reg;
        word_open_next     = word_open_reg;
        ws_pending_next    = ws_pending_reg;
        ws_char_next       = ws_char_reg;
        char_pos_next      = char_pos_reg;
        oq_pos_next        = oq_pos_reg;
        words_next         = words_reg;
        err_code_next      = err_code_reg;
        err_at_next        = err_at_reg;
        bundle             = '0;
        n                  = '0;
        take_ok            = 1'b0;
        upd_ps             = 1'b0;

        if (!s_no_char) begin
            if (err_code_reg == qat_pkg::ST_OK) begin
                take_ok = 1'b1;
                // A closing quote seen last beat must be followed by a space.
                if (close_pending_reg) begin
                    close_pending_next = 1'b0;
                    if (s_char_in != qat_pkg::CH_SPACE) begin
                        err_code_next = qat_pkg::ST_NONISO;
                        take_ok       = 1'b0;
                    end else if (close_empty_reg) begin
                        err_code_next = qat_pkg::ST_EMPTYQ;
                        take_ok       = 1'b0;
                    end
                end
                if (take_ok) begin
                    upd_ps = 1'b1;
                    if (s_char_in == qat_pkg::CH_QUOTE) begin
                        if (in_quotes_reg) begin
                            in_quotes_next     = 1'b0;
                            ws_pending_next    = 1'b0;
                            err_at_next        = char_pos_reg;
                            close_pending_next = 1'b1;
                            if (word_open_reg) begin
                                bundle.slot[n[1:0]].kind = qat_pkg::KIND_WEND;
                                n = n + 3'd1;
                                if (words_next < qat_pkg::WORDS_CAP) begin
                                    words_next = words_next + 10'd1;
                                end
                                word_open_next   = 1'b0;
                                close_empty_next = 1'b0;
                            end else begin
                                close_empty_next = 1'b1;
                            end
                        end else if (!prev_space_reg) begin
                            err_code_next = qat_pkg::ST_NONISO;
                            err_at_next   = char_pos_reg;
                            upd_ps        = 1'b0;
                        end else begin
                            in_quotes_next = 1'b1;
                            oq_pos_next    = char_pos_reg;
                            word_open_next = 1'b0;
                        end
                    end else if (in_quotes_reg) begin
                        if (s_char_in == qat_pkg::CH_SPACE || s_char_in == qat_pkg::CH_TAB) begin
                            if (word_open_reg && !ws_pending_reg) begin
                                ws_pending_next = 1'b1;
                                ws_char_next    = s_char_in;
                            end
                        end else begin
                            if (ws_pending_reg) begin
                                bundle.slot[n[1:0]].kind = qat_pkg::KIND_BYTE;
                                bundle.slot[n[1:0]].data = ws_char_reg;
                                n = n + 3'd1;
                            end
                            ws_pending_next = 1'b0;
                            bundle.slot[n[1:0]].kind = qat_pkg::KIND_BYTE;
                            bundle.slot[n[1:0]].data = s_char_in;
                            n = n + 3'd1;
                            word_open_next = 1'b1;
                        end
                    end else if (s_char_in == qat_pkg::CH_SPACE) begin
                        if (word_open_reg) begin
                            bundle.slot[n[1:0]].kind = qat_pkg::KIND_WEND;
                            n = n + 3'd1;
                            if (words_next < qat_pkg::WORDS_CAP) begin
                                words_next = words_next + 10'd1;
                            end
                            word_open_next = 1'b0;
                        end
                    end else begin
                        bundle.slot[n[1:0]].kind = qat_pkg::KIND_BYTE;
                        bundle.slot[n[1:0]].data = s_char_in;
                        n = n + 3'd1;
                        word_open_next = 1'b1;
                    end
                    if (upd_ps) begin
                        prev_space_next = (s_char_in == qat_pkg::CH_SPACE);
                    end
                end
            end
            if (char_pos_reg < POS_CAP) begin
                char_pos_next = char_pos_reg + 10'd1;
            end
        end

        if (s_no_char || s_line_end) begin
            if (err_code_next == qat_pkg::ST_OK) begin
                if (close_pending_next && close_empty_next) begin
                    err_code_next = qat_pkg::ST_EMPTYQ;
                end else if (in_quotes_next) begin
                    err_code_next = qat_pkg::ST_UNPAIRED;
                    err_at_next   = oq_pos_next;
                end else begin
                    if (word_open_next) begin
                        bundle.slot[n[1:0]].kind = qat_pkg::KIND_WEND;
                        n = n + 3'd1;
                        if (words_next < qat_pkg::WORDS_CAP) begin
                            words_next = words_next + 10'd1;
                        end
                    end
                    if (words_next == '0) begin
                        err_code_next = qat_pkg::ST_EMPTY;
                        err_at_next   = '0;
                    end
                end
            end
            bundle.slot[n[1:0]].kind = qat_pkg::KIND_STAT;
            n = n + 3'd1;
            bundle.status     = err_code_next;
            bundle.error_pos  = (err_code_next != qat_pkg::ST_OK) ? err_at_next : '0;
            bundle.quote_pos  = oq_pos_next;
            bundle.word_total = words_next;
            // The line is done: back to the line-start state.
            in_quotes_next     = 1'b0;
            prev_space_next    = 1'b1;
            close_pending_next = 1'b0;
            close_empty_next   = 1'b0;
            word_open_next     = 1'b0;
            ws_pending_next    = 1'b0;
            ws_char_next       = '0;
            char_pos_next      = '0;
            oq_pos_next        = '0;
            words_next         = '0;
            err_code_next      = qat_pkg::ST_OK;
            err_at_next        = '0;
        end
        bundle.count = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_quotes_reg     <= 1'b0;
            prev_space_reg    <= 1'b1;
            close_pending_reg <= 1'b0;
            close_empty_reg   <= 1'b0;
            word_open_reg     <= 1'b0;
            ws_pending_reg    <= 1'b0;
            ws_char_reg       <= '0;
            char_pos_reg      <= '0;
            oq_pos_reg        <= '0;
            words_reg         <= '0;
            err_code_reg      <= qat_pkg::ST_OK;
            err_at_reg        <= '0;
        end else if (accept) begin
            in_quotes_reg     <= in_quotes_next;
            prev_space_reg    <= prev_space_next;
            close_pending_reg <= close_pending_next;
            close_empty_reg   <= close_empty_next;
            word_open_reg     <= word_open_next;
            ws_pending_reg    <= ws_pending_next;
            ws_char_reg       <= ws_char_next;
            char_pos_reg      <= char_pos_next;
            oq_pos_reg        <= oq_pos_next;
            words_reg         <= words_next;
            err_code_reg      <= err_code_next;
            err_at_reg        <= err_at_next;
        end
    end

    // Every line end produces a bundle that finishes with a status result.
    a_line_end_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_no_char || s_line_end)) |->
            (push && bundle.slot[2'(bundle.count - 3'd1)].kind == qat_pkg::KIND_STAT))
        else $error("line end without a status result");

    // The pushed bundle never holds more results than it has slots.
    a_bundle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (bundle.count <= 3'(qat_pkg::SLOTS)))
        else $error("bundle overflow");

endmodule

// ===== rtl/core/qat_queue.sv =====
// ----------------------------------------------------------------------------
// qat_queue: bundle queue between the front and back end
// A small register queue that lets the classifier and the serializer stall
// independently.
// ----------------------------------------------------------------------------
module qat_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  qat_pkg::qat_bundle_t   push_data,
    input  logic                   pop,
    output qat_pkg::qat_bundle_t   head,
    output qat_pkg::qat_qstat_t    qstat
);

    qat_pkg::qat_bundle_t         mem_reg [qat_pkg::QDEPTH];
    logic [qat_pkg::QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [qat_pkg::QCNT_W-1:0]   count_reg, count_next;

    assign head        = mem_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == qat_pkg::QCNT_W'(qat_pkg::QDEPTH));
    assign qstat.empty = (count_reg == '0);

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 3'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_next;
        end
    end

    // Occupancy stays within the queue depth.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= qat_pkg::QCNT_W'(qat_pkg::QDEPTH))
        else $error("queue occupancy out of range");

    // Pointers stay apart by the occupancy, counted modulo the queue depth.
    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[qat_pkg::QPTR_W-1:0])
        else $error("queue pointers out of step with occupancy");

endmodule

// ===== rtl/core/qat_back.sv =====
// ----------------------------------------------------------------------------
// qat_back: result serializer of the tokenizer
// Walks the slots of the bundle at the queue head and sends one result beat
// per cycle while m_ready is high, marking the last result of each bundle.
// ----------------------------------------------------------------------------
module qat_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  qat_pkg::qat_bundle_t       head,
    input  qat_pkg::qat_qstat_t        qstat,
    output logic                       pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_kind,
    output logic [7:0]                 m_byte_out,
    output logic [2:0]                 m_status,
    output logic [qat_pkg::POS_W-1:0]  m_error_pos,
    output logic [qat_pkg::POS_W-1:0]  m_quote_pos,
    output logic [qat_pkg::POS_W-1:0]  m_word_total,
    output logic                       m_final_res
);

    logic [1:0]          idx_reg;
    logic                last;
    logic                is_stat;
    qat_pkg::qat_slot_t  cur;

    assign cur     = head.slot[idx_reg];
    assign last    = ({1'b0, idx_reg} == (head.count - 3'd1));
    assign is_stat = (cur.kind == qat_pkg::KIND_STAT);

    assign m_valid      = !qstat.empty;
    assign m_kind       = cur.kind;
    assign m_byte_out   = (cur.kind == qat_pkg::KIND_BYTE) ? cur.data : 8'd0;
    assign m_status     = is_stat ? head.status : 3'd0;
    assign m_error_pos  = is_stat ? head.error_pos : '0;
    assign m_quote_pos  = is_stat ? head.quote_pos : '0;
    assign m_word_total = is_stat ? head.word_total : '0;
    assign m_final_res  = last;
    assign pop          = m_valid && m_ready && last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (m_valid && m_ready) begin
            idx_reg <= last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    // The slot pointer never runs past the bundle it is walking.
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, idx_reg} < head.count))
        else $error("slot index beyond bundle count");

endmodule

// ===== rtl/core/quoted_argument_tokenizer.sv =====
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer: command line word splitter with quote handling
// Takes one character beat per cycle while the bundle queue has room, streams
// word bytes and word ends, and closes each line with a status beat that
// carries positions and word count.
// Results of an accepted character wait in the bundle queue and leave from its head.
// Throughput: one character beat per cycle while each causes at most one result and
//   the output is ready; the result port sends one beat per cycle, one per result.
// The four-entry bundle queue between classifier and serializer absorbs these bursts.
// Reset: synchronous, active low; clears the line state to line start and empties the
//   queue; no clearing pass is needed, the block is ready as soon as reset is released.
module quoted_argument_tokenizer #(
    parameter int MAX_LINE = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Character input channel.
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_char_in,
    input  logic                       s_no_char,
    input  logic                       s_line_end,
    // Result output channel.
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_kind,
    output logic [7:0]                 m_byte_out,
    output logic [2:0]                 m_status,
    output logic [qat_pkg::POS_W-1:0]  m_error_pos,
    output logic [qat_pkg::POS_W-1:0]  m_quote_pos,
    output logic [qat_pkg::POS_W-1:0]  m_word_total,
    output logic                       m_final_res
);

    // The front end classifies every accepted character and packs all results
    // that it causes (at most four: a held whitespace byte, the character, a
    // word end and the line status) into one bundle.
    logic                  push;
    logic                  pop;
    qat_pkg::qat_bundle_t  push_data;
    qat_pkg::qat_bundle_t  head;
    qat_pkg::qat_qstat_t   qstat;

    qat_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_char_in  (s_char_in),
        .s_no_char  (s_no_char),
        .s_line_end (s_line_end),
        .qstat      (qstat),
        .push       (push),
        .push_data  (push_data)
    );

    // Bundles wait here, so the input keeps flowing while the output is stalled
    // or busy with a multi-result bundle.
    qat_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    // The back end sends the bundle at the head one result beat at a time and
    // releases it after its final beat.
    qat_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head),
        .qstat        (qstat),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_byte_out   (m_byte_out),
        .m_status     (m_status),
        .m_error_pos  (m_error_pos),
        .m_quote_pos  (m_quote_pos),
        .m_word_total (m_word_total),
        .m_final_res  (m_final_res)
    );

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for quoted_argument_tokenizer
// Streams command lines into the tokenizer one character beat at a time and
// checks every result beat against a cycle-free model of the line parser that
// runs on each accepted character. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_MAX = 1024;
    // Character positions saturate at the smaller of LINE_MAX - 1 and 1023.
    localparam logic [qat_pkg::POS_W-1:0] POS_CAP =
        (LINE_MAX - 1 < 1023) ? qat_pkg::POS_W'(LINE_MAX - 1) : qat_pkg::POS_W'(1023);

    // One character beat as the sender queues it. A beat marked settle is
    // held back until every result that is still owed has come out.
    typedef struct {
        logic [7:0] ch;
        logic       nc;
        logic       le;
        logic       settle;
    } char_beat_t;

    // One result beat, all fields packed so that a single compare covers them.
    typedef struct packed {
        logic [1:0]                kind;
        logic [7:0]                data;
        logic [2:0]                status;
        logic [qat_pkg::POS_W-1:0] err_pos;
        logic [qat_pkg::POS_W-1:0] quote_pos;
        logic [qat_pkg::POS_W-1:0] words;
        logic                      last;
    } tok_result_t;

    // Shapes of the words that the random line builder strings together.
    typedef enum int {
        FORM_PLAIN,
        FORM_QUOTED,
        FORM_GLUED_OPEN,
        FORM_GLUED_CLOSE,
        FORM_EMPTY_QUOTED,
        FORM_UNPAIRED,
        FORM_NOISE
    } word_form_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the ports of the block.
    // ------------------------------------------------------------------------
    logic                      aclk    = 1'b0;
    logic                      aresetn = 1'b0;

    logic                      s_valid    = 1'b0;
    logic                      s_ready;
    logic [7:0]                s_char_in  = 8'h00;
    logic                      s_no_char  = 1'b0;
    logic                      s_line_end = 1'b0;

    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [1:0]                m_kind;
    logic [7:0]                m_byte_out;
    logic [2:0]                m_status;
    logic [qat_pkg::POS_W-1:0] m_error_pos;
    logic [qat_pkg::POS_W-1:0] m_quote_pos;
    logic [qat_pkg::POS_W-1:0] m_word_total;
    logic                      m_final_res;

    quoted_argument_tokenizer #(
        .MAX_LINE (LINE_MAX)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_char_in    (s_char_in),
        .s_no_char    (s_no_char),
        .s_line_end   (s_line_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_byte_out   (m_byte_out),
        .m_status     (m_status),
        .m_error_pos  (m_error_pos),
        .m_quote_pos  (m_quote_pos),
        .m_word_total (m_word_total),
        .m_final_res  (m_final_res)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Reset is held at the start and never again.
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Shared bench state.
    // ------------------------------------------------------------------------
    char_beat_t  pending_chars[$];     // Beats not yet offered to the block.
    tok_result_t expected_results[$];  // Results owed by accepted beats.
    tok_result_t step_results[$];      // Results of the beat being modeled.
    logic [7:0]  line_text[$];         // Line under construction.

    int         items_queued  = 0;
    logic       settle_next   = 1'b0;
    int         chars_sent    = 0;
    int         beats_checked = 0;
    int         lines_closed  = 0;
    int         fail_count    = 0;
    int         status_seen[5];

    // ------------------------------------------------------------------------
    // Line parser model. It holds the same line state as the block and is
    // advanced once for every character beat that the block accepts.
    // ------------------------------------------------------------------------
    logic                      lp_in_quotes;
    logic                      lp_prev_space;
    logic                      lp_close_pend;
    logic                      lp_close_empty;  // The quoted word just closed held nothing.
    logic                      lp_word_open;
    logic                      lp_ws_pend;
    logic [7:0]                lp_ws_char;
    logic [qat_pkg::POS_W-1:0] lp_pos;
    logic [qat_pkg::POS_W-1:0] lp_open_pos;
    logic [qat_pkg::POS_W-1:0] lp_words;
    logic [2:0]                lp_err;
    logic [qat_pkg::POS_W-1:0] lp_err_at;

    task automatic line_state_clear();
        lp_in_quotes   = 1'b0;
        lp_prev_space  = 1'b1;   // The line start counts as a space.
        lp_close_pend  = 1'b0;
        lp_close_empty = 1'b0;
        lp_word_open   = 1'b0;
        lp_ws_pend     = 1'b0;
        lp_ws_char     = 8'h00;
        lp_pos         = '0;
        lp_open_pos    = '0;
        lp_words       = '0;
        lp_err         = qat_pkg::ST_OK;
        lp_err_at      = '0;
    endtask

    task automatic emit_result(input logic [1:0] kind, input logic [7:0] data,
                               input logic [2:0] status,
                               input logic [qat_pkg::POS_W-1:0] err_pos,
                               input logic [qat_pkg::POS_W-1:0] quote_pos,
                               input logic [qat_pkg::POS_W-1:0] words);
        tok_result_t r;
        r.kind      = kind;
        r.data      = data;
        r.status    = status;
        r.err_pos   = err_pos;
        r.quote_pos = quote_pos;
        r.words     = words;
        r.last      = 1'b0;
        step_results.insert(step_results.size(), r);
    endtask

    task automatic close_word();
        emit_result(qat_pkg::KIND_WEND, 8'h00, qat_pkg::ST_OK, '0, '0, '0);
        if (lp_words < qat_pkg::WORDS_CAP) lp_words++;
        lp_word_open = 1'b0;
    endtask

    // One character of a line that has no error latched yet.
    task automatic parse_char(input logic [7:0] c);
        logic [qat_pkg::POS_W-1:0] pos;
        logic                      stop;
        pos  = lp_pos;
        stop = 1'b0;
        // A closing quote is only judged once the character after it is known:
        // it must be a space, and the quoted word must not have been empty.
        if (lp_close_pend) begin
            lp_close_pend = 1'b0;
            if (c != qat_pkg::CH_SPACE) begin
                lp_err = qat_pkg::ST_NONISO;
                stop   = 1'b1;
            end else if (lp_close_empty) begin
                lp_err = qat_pkg::ST_EMPTYQ;
                stop   = 1'b1;
            end
        end
        if (!stop) begin
            if (c == qat_pkg::CH_QUOTE) begin
                if (lp_in_quotes) begin
                    lp_in_quotes  = 1'b0;
                    lp_ws_pend    = 1'b0;   // Trailing whitespace is dropped.
                    lp_err_at     = pos;
                    lp_close_pend = 1'b1;
                    if (lp_word_open) begin
                        close_word();
                        lp_close_empty = 1'b0;
                    end else begin
                        lp_close_empty = 1'b1;
                    end
                end else if (!lp_prev_space) begin
                    lp_err    = qat_pkg::ST_NONISO;
                    lp_err_at = pos;
                    stop      = 1'b1;
                end else begin
                    lp_in_quotes = 1'b1;
                    lp_open_pos  = pos;
                    lp_word_open = 1'b0;
                end
            end else if (lp_in_quotes) begin
                if (c == qat_pkg::CH_SPACE || c == qat_pkg::CH_TAB) begin
                    // Leading whitespace is dropped, and an inner run keeps
                    // only its first character, sent once more text follows.
                    if (lp_word_open && !lp_ws_pend) begin
                        lp_ws_pend = 1'b1;
                        lp_ws_char = c;
                    end
                end else begin
                    if (lp_ws_pend)
                        emit_result(qat_pkg::KIND_BYTE, lp_ws_char, qat_pkg::ST_OK,
                                    '0, '0, '0);
                    lp_ws_pend = 1'b0;
                    emit_result(qat_pkg::KIND_BYTE, c, qat_pkg::ST_OK, '0, '0, '0);
                    lp_word_open = 1'b1;
                end
            end else if (c == qat_pkg::CH_SPACE) begin
                if (lp_word_open) close_word();
            end else begin
                // Outside quotes a tab is an ordinary word character.
                emit_result(qat_pkg::KIND_BYTE, c, qat_pkg::ST_OK, '0, '0, '0);
                lp_word_open = 1'b1;
            end
            if (!stop) lp_prev_space = (c == qat_pkg::CH_SPACE);
        end
    endtask

    task automatic parse_line_end();
        if (lp_err == qat_pkg::ST_OK) begin
            if (lp_close_pend && lp_close_empty) begin
                lp_err = qat_pkg::ST_EMPTYQ;   // Error position is the closing quote.
            end else if (lp_in_quotes) begin
                lp_err    = qat_pkg::ST_UNPAIRED;
                lp_err_at = lp_open_pos;
            end else begin
                if (lp_word_open) close_word();
                if (lp_words == 0) begin
                    lp_err    = qat_pkg::ST_EMPTY;
                    lp_err_at = '0;
                end
            end
        end
        emit_result(qat_pkg::KIND_STAT, 8'h00, lp_err,
                    (lp_err != qat_pkg::ST_OK) ? lp_err_at : '0, lp_open_pos, lp_words);
        line_state_clear();
    endtask

    // Works out all results of one accepted beat and queues them in order,
    // with the last one flagged.
    task automatic parse_beat(input logic [7:0] c, input logic nc, input logic le);
        tok_result_t r;
        step_results.delete();
        if (!nc) begin
            // Once an error is latched the rest of the line only moves the position.
            if (lp_err == qat_pkg::ST_OK) parse_char(c);
            if (lp_pos < POS_CAP) lp_pos++;
        end
        if (nc || le) parse_line_end();
        if (step_results.size() != 0) begin
            r      = step_results.pop_back();
            r.last = 1'b1;
            step_results.insert(step_results.size(), r);
        end
        foreach (step_results[i])
            expected_results.insert(expected_results.size(), step_results[i]);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus building.
    // ------------------------------------------------------------------------
    task automatic push_item(input logic [7:0] ch, input logic nc, input logic le);
        char_beat_t b;
        b.ch     = ch;
        b.nc     = nc;
        b.le     = le;
        b.settle = settle_next;
        settle_next = 1'b0;
        pending_chars.insert(pending_chars.size(), b);
        items_queued++;
    endtask

    // A whole line given as text; its last character carries the line end.
    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_item(s[i], 1'b0, i == s.len() - 1);
    endtask

    // Appends one character to the line under construction.
    task automatic add_char(input logic [7:0] c);
        line_text.insert(line_text.size(), c);
    endtask

    // A character that may stand in a word: mostly letters, sometimes tabs,
    // sometimes any byte that is neither space nor quote.
    function automatic logic [7:0] word_char();
        logic [7:0] c;
        case ($urandom_range(0, 7))
            0:       c = qat_pkg::CH_TAB;
            1, 2:    c = 8'($urandom_range(0, 255));
            default: c = 8'($urandom_range(8'h61, 8'h7a));
        endcase
        if (c == qat_pkg::CH_SPACE || c == qat_pkg::CH_QUOTE) c = 8'h5f;
        return c;
    endfunction

    task automatic add_word_chars(input int n);
        for (int i = 0; i < n; i++) add_char(word_char());
    endtask

    task automatic add_quoted_ws(input int n);
        for (int i = 0; i < n; i++)
            add_char($urandom_range(0, 1) ? qat_pkg::CH_SPACE : qat_pkg::CH_TAB);
    endtask

    task automatic add_word(input word_form_t form);
        int segs;
        case (form)
            FORM_PLAIN: add_word_chars($urandom_range(1, 4));
            FORM_QUOTED: begin
                segs = $urandom_range(1, 3);
                add_char(qat_pkg::CH_QUOTE);
                add_quoted_ws($urandom_range(0, 2));
                for (int s = 0; s < segs; s++) begin
                    if (s > 0) add_quoted_ws($urandom_range(1, 3));
                    add_word_chars($urandom_range(1, 3));
                end
                add_quoted_ws($urandom_range(0, 2));
                add_char(qat_pkg::CH_QUOTE);
            end
            FORM_GLUED_OPEN: begin
                add_word_chars($urandom_range(1, 2));
                add_char(qat_pkg::CH_QUOTE);
                add_word_chars($urandom_range(1, 2));
                add_char(qat_pkg::CH_QUOTE);
            end
            FORM_GLUED_CLOSE: begin
                add_char(qat_pkg::CH_QUOTE);
                add_word_chars($urandom_range(1, 2));
                add_char(qat_pkg::CH_QUOTE);
                add_word_chars($urandom_range(1, 2));
            end
            FORM_EMPTY_QUOTED: begin
                add_char(qat_pkg::CH_QUOTE);
                add_quoted_ws($urandom_range(0, 3));
                add_char(qat_pkg::CH_QUOTE);
            end
            FORM_UNPAIRED: begin
                add_char(qat_pkg::CH_QUOTE);
                add_word_chars($urandom_range(1, 3));
            end
            default: begin
                for (int i = $urandom_range(1, 4); i > 0; i--)
                    add_char($urandom_range(0, 3) == 0 ? qat_pkg::CH_QUOTE
                                                       : 8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // Most lines are well formed with random content; a share carries
    // misplaced, empty or unpaired quotes, or plain noise.
    task automatic random_line();
        int         n_words;
        int         pick;
        int         cut_at;
        word_form_t form;
        n_words = $urandom_range(0, 4);
        line_text.delete();
        if ($urandom_range(0, 3) == 0) add_char(qat_pkg::CH_SPACE);
        for (int w = 0; w < n_words; w++) begin
            if (w > 0)
                for (int i = $urandom_range(1, 2); i > 0; i--) add_char(qat_pkg::CH_SPACE);
            pick = $urandom_range(0, 19);
            if (pick < 10)       form = FORM_PLAIN;
            else if (pick < 15)  form = FORM_QUOTED;
            else if (pick == 15) form = FORM_GLUED_OPEN;
            else if (pick == 16) form = FORM_GLUED_CLOSE;
            else if (pick == 17) form = FORM_EMPTY_QUOTED;
            else if (pick == 18) form = FORM_UNPAIRED;
            else                 form = FORM_NOISE;
            add_word(form);
        end
        if ($urandom_range(0, 3) == 0) add_char(qat_pkg::CH_SPACE);
        if ($urandom_range(0, 29) == 0) settle_next = 1'b1;

        if (line_text.size() == 0) begin
            // Nothing to send: the line is reported empty by a beat without a character.
            push_item(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
        end else if ($urandom_range(0, 11) == 0) begin
            // The line is cut short by a beat without a character.
            cut_at = $urandom_range(0, line_text.size() - 1);
            for (int i = 0; i < cut_at; i++) push_item(line_text[i], 1'b0, 1'b0);
            push_item(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
        end else begin
            foreach (line_text[i]) push_item(line_text[i], 1'b0, i == line_text.size() - 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender: offers the queued beats, models each one as it is accepted, and
    // draws a random pause before the next. Now and then it switches into a
    // burst mode that sends back to back.
    // ------------------------------------------------------------------------
    char_beat_t next_beat;
    int         send_gap   = 0;
    logic       send_burst = 1'b0;

    always @(posedge aclk) begin
        if (s_valid && s_ready) begin
            parse_beat(s_char_in, s_no_char, s_line_end);
            chars_sent++;
            send_gap = send_burst ? 0 : $urandom_range(0, 3);
            if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
        end
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_ready) begin
            // The offered beat stays on the port until it is taken.
        end else if (send_gap > 0) begin
            send_gap--;
            s_valid <= 1'b0;
        end else if (pending_chars.size() != 0 &&
                     !(pending_chars[0].settle && expected_results.size() != 0)) begin
            next_beat  = pending_chars.pop_front();
            s_valid    <= 1'b1;
            s_char_in  <= next_beat.ch;
            s_no_char  <= next_beat.nc;
            s_line_end <= next_beat.le;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: takes result beats with random stalls and compares each one
    // against the oldest result still owed.
    // ------------------------------------------------------------------------
    int          take_gap   = 0;
    logic        take_burst = 1'b0;
    tok_result_t seen_beat;
    tok_result_t owed_beat;

    function automatic string describe(input tok_result_t r);
        return $sformatf({"kind %0d byte %02h status %0d err_pos %0d ",
                          "quote_pos %0d words %0d last %0b"},
                         r.kind, r.data, r.status, r.err_pos, r.quote_pos, r.words, r.last);
    endfunction

    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            seen_beat.kind      = m_kind;
            seen_beat.data      = m_byte_out;
            seen_beat.status    = m_status;
            seen_beat.err_pos   = m_error_pos;
            seen_beat.quote_pos = m_quote_pos;
            seen_beat.words     = m_word_total;
            seen_beat.last      = m_final_res;
            beats_checked++;
            if (expected_results.size() == 0) begin
                if (fail_count < 10)
                    $display("Unexpected result beat at %0t: %s", $realtime,
                             describe(seen_beat));
                fail_count++;
            end else begin
                owed_beat = expected_results.pop_front();
                if (seen_beat !== owed_beat) begin
                    if (fail_count < 10) begin
                        $display("Result mismatch at %0t", $realtime);
                        $display("  expected %s", describe(owed_beat));
                        $display("  actual   %s", describe(seen_beat));
                    end
                    fail_count++;
                end
            end
            if (m_kind == qat_pkg::KIND_STAT) begin
                lines_closed++;
                if (m_status <= qat_pkg::ST_UNPAIRED) status_seen[m_status]++;
            end
            take_gap = take_burst ? 0 : $urandom_range(0, 3);
            if ($urandom_range(0, 19) == 0) take_burst = !take_burst;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (take_gap > 0) begin
            take_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: directed lines, two batches of random lines that each
    // start only once the block has drained, then drain and report.
    // ------------------------------------------------------------------------
    initial begin
        int target;
        line_state_clear();
        foreach (status_seen[i]) status_seen[i] = 0;

        // An empty line given by a beat without a character.
        push_item(8'hFF, 1'b1, 1'b1);
        // Tab and the highest byte form an ordinary word, then the line is
        // cut by a beat without a character that does not mark the line end.
        push_item(qat_pkg::CH_TAB, 1'b0, 1'b0);
        push_item(8'hFF, 1'b0, 1'b0);
        push_item(8'h00, 1'b1, 1'b0);
        // Quoted word: leading and trailing whitespace dropped, the inner run
        // shrunk to its first character, closed right at the line end.
        push_text("\" a \tb \"");
        // Opening quote glued to a word.
        push_text("x\"");
        // Closing quote glued to a word.
        push_text("\"a\"b");
        // Empty quoted word followed by a space; the rest of the line is ignored.
        push_text("\" \" c");
        // Quote never closed.
        push_text("\"a");
        // Empty quoted word at the line end.
        push_text("\"\"");
        // A line of one space holds no word.
        push_text(" ");

        settle_next = 1'b1;
        target = items_queued + 45;
        while (items_queued < target) random_line();
        settle_next = 1'b1;
        target = items_queued + 45;
        while (items_queued < target) random_line();

        @(posedge aclk iff aresetn);
        do @(posedge aclk);
        while (pending_chars.size() != 0 || s_valid || expected_results.size() != 0);
        // Keep the clock running so that any stray beat is caught.
        repeat (20) @(posedge aclk);

        $display("Sent %0d character beats and checked %0d result beats over %0d lines.",
                 chars_sent, beats_checked, lines_closed);
        $display({"Line status: %0d ok, %0d empty, %0d misplaced quote, ",
                  "%0d empty quoted, %0d unpaired."},
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("PASS quoted_argument_tokenizer");
        end else begin
            $display("FAIL quoted_argument_tokenizer");
        end
        $finish;
    end

    // Hard stop far beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("Timeout with %0d results still owed.", expected_results.size());
        $display("FAIL quoted_argument_tokenizer");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/qat_pkg.sv
rtl/core/qat_front.sv
rtl/core/qat_queue.sv
rtl/core/qat_back.sv
rtl/core/quoted_argument_tokenizer.sv
sim/tb.sv
